// File: src/utf8d_pkg.sv
`default_nettype none
package utf8d_pkg;

  localparam logic [7:0]  BYTE_HI_BIT    = 8'h80;
  localparam logic [7:0]  BYTE_LEAD_BIT  = 8'h40;
  localparam logic [7:0]  PAYLOAD_MASK   = 8'h3F;
  localparam logic [7:0]  CONT_SEL       = 8'hC0;
  localparam logic [7:0]  CONT_TAG       = 8'h80;
  localparam logic [7:0]  FULL_MASK      = 8'hFF;
  localparam logic [30:0] MAX_CODE_POINT = 31'h10FFFF;
  localparam logic [30:0] SURR_LO        = 31'hD800;
  localparam logic [30:0] SURR_HI        = 31'hDFFF;

  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_IDX_W      = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_error;
    logic [2:0]  seq_bytes;
    logic        run_last;
  } utf8d_res_t;

  typedef struct packed {
    logic [30:0] partial_value;
    logic [2:0]  expected_len;
    logic [2:0]  bytes_seen;
    logic [7:0]  lead_mask;
  } utf8d_state_t;

  typedef struct packed {
    logic [1:0] cnt;
    utf8d_res_t res0;
    utf8d_res_t res1;
  } utf8d_push_t;

  // sequence length from the low six bits of a lead byte, 0 for illegal leads
  function automatic logic [2:0] lead_len(input logic [5:0] low);
    logic [2:0] n;
    if (!low[5]) begin
      n = (low[4:1] == 4'b0000) ? 3'd0 : 3'd2;
    end else if (low[5:4] == 2'b10) begin
      n = 3'd3;
    end else if (low[5:3] == 3'b110) begin
      n = 3'd4;
    end else if (low[5:2] == 4'b1110) begin
      n = 3'd5;
    end else if (low[5:1] == 5'b11110) begin
      n = 3'd6;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: src/utf8d_step.sv
`default_nettype none
module utf8d_step (
  input  wire logic [7:0]             data_byte,
  input  wire logic                   end_of_buffer,
  input  wire utf8d_pkg::utf8d_state_t state,
  output utf8d_pkg::utf8d_state_t     state_nxt,
  output utf8d_pkg::utf8d_push_t      push
);
  import utf8d_pkg::*;

  logic [2:0]   len;
  logic [7:0]   mask;
  logic         start_has;
  utf8d_res_t   start_res;
  utf8d_state_t start_st;
  logic [30:0]  pv_ext;
  logic [2:0]   seen_inc;
  logic         bad;

  // decode of the byte as a fresh start
  always_comb begin
    len       = lead_len(data_byte[5:0]);
    mask      = FULL_MASK >> len;
    start_has = 1'b0;
    start_res = '0;
    start_st  = '0;
    if ((data_byte & BYTE_HI_BIT) == 8'h00) begin
      start_has            = 1'b1;
      start_res.code_point = {13'b0, data_byte};
      start_res.seq_bytes  = 3'd1;
    end else if ((data_byte & BYTE_LEAD_BIT) == 8'h00 || len == 3'd0) begin
      start_has           = 1'b1;
      start_res.is_error  = 1'b1;
      start_res.seq_bytes = 3'd1;
    end else begin
      start_st.expected_len  = len;
      start_st.bytes_seen    = 3'd1;
      start_st.lead_mask     = mask;
      start_st.partial_value = {23'b0, data_byte & mask};
    end
  end

  always_comb begin
    pv_ext    = {state.partial_value[24:0], data_byte[5:0]};
    seen_inc  = state.bytes_seen + 3'd1;
    bad       = (pv_ext > MAX_CODE_POINT) || (pv_ext >= SURR_LO && pv_ext <= SURR_HI);
    state_nxt = state;
    push      = '0;
    if (state.expected_len == 3'd0) begin
      state_nxt = start_st;
      push.res0 = start_res;
      push.cnt  = {1'b0, start_has};
    end else if ((data_byte & CONT_SEL) != CONT_TAG) begin
      // broken sequence, then the byte starts over
      push.res0.is_error  = 1'b1;
      push.res0.seq_bytes = state.bytes_seen;
      push.res1           = start_res;
      push.cnt            = start_has ? 2'd2 : 2'd1;
      state_nxt           = start_st;
    end else begin
      state_nxt.partial_value = pv_ext;
      state_nxt.bytes_seen    = seen_inc;
      if (seen_inc == 3'd2 && pv_ext <= {23'b0, state.lead_mask}) begin
        push.res0.is_error  = 1'b1;
        push.res0.seq_bytes = 3'd2;
        push.cnt            = 2'd1;
        state_nxt           = '0;
      end else if (seen_inc >= state.expected_len) begin
        push.res0.code_point = bad ? 21'd0 : pv_ext[20:0];
        push.res0.is_error   = bad;
        push.res0.seq_bytes  = state.expected_len;
        push.cnt             = 2'd1;
        state_nxt            = '0;
      end
    end
    if (end_of_buffer && state_nxt.expected_len != 3'd0) begin
      state_nxt = '0;
    end
    if (push.cnt == 2'd2) begin
      push.res1.run_last = 1'b1;
    end else if (push.cnt == 2'd1) begin
      push.res0.run_last = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: src/utf8d_res_fifo.sv
`default_nettype none
module utf8d_res_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire utf8d_pkg::utf8d_push_t push,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output utf8d_pkg::utf8d_res_t      out_res
);
  import utf8d_pkg::*;

  utf8d_res_t           mem_r [RES_FIFO_DEPTH];
  logic [RES_IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic [RES_IDX_W-1:0] wr_ptr_p1;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for two results regardless of what leaves this cycle
  assign room      = (count_r <= RES_CNT_W'(RES_FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + RES_IDX_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_IDX_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RES_IDX_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/utf8_stream_decoder_core.sv
// utf8_stream_decoder_core: byte-serial UTF-8 decoder.
// Input channel in_*: one raw byte per transaction in in_tdata, in_tlast marks
// the last byte of a buffer; a sequence still open after that byte is dropped.
// Output channel out_*: one result per transaction; out_tdata carries the
// code point and the number of bytes consumed, out_tuser flags an error and
// out_tlast marks the final result caused by one input byte. A byte can
// cause zero, one or two results.
// A result passes through the input register and then the result queue
// before it can leave.
// Throughput: one byte per cycle while the queue has room; a byte that yields
// two results pushes both at once, and the output side drains them one per
// cycle while out_tready is high. The four-entry result queue accepts a byte
// only while it has room for two results. When the receiver stalls, the queue
// fills and in_tready falls; nothing is lost. Reset (rst_n low, synchronous)
// empties the queue and closes any open sequence.
`default_nettype none
module utf8_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tlast,   // end_of_buffer
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // code_point[20:0], seq_bytes[23:21]
  output logic             out_tuser,  // is_error
  output logic             out_tlast   // run_last
);
  import utf8d_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_eob_r;
  logic         s1_go;
  logic         room;
  utf8d_state_t state_r, state_nxt, step_state;
  utf8d_push_t  step_push, push;
  utf8d_res_t   out_res;

  assign s1_go        = s1_valid_r && room;
  assign in_tready    = !s1_valid_r || s1_go;
  assign s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s1_go);
  assign state_nxt    = s1_go ? step_state : state_r;

  always_comb begin
    push = step_push;
    if (!s1_go) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_eob_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      state_r    <= state_nxt;
    end
  end

  utf8d_step u_step (
    .data_byte     (s1_byte_r),
    .end_of_buffer (s1_eob_r),
    .state         (state_r),
    .state_nxt     (step_state),
    .push          (step_push)
  );

  utf8d_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.seq_bytes, out_res.code_point};
  assign out_tuser = out_res.is_error;
  assign out_tlast = out_res.run_last;

endmodule
`default_nettype wire
